### hw/rtl/stdp_synapse_weight_update_unit_macros.svh
// ----------------------------------------------------------------------------
// STDP synapse update unit assertion macros
// Shared concurrent assertion wrappers, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef STDP_SYNAPSE_WEIGHT_UPDATE_UNIT_MACROS_SVH
`define STDP_SYNAPSE_WEIGHT_UPDATE_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SWU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SWU_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### hw/rtl/stdp_pkg.sv
// ----------------------------------------------------------------------------
// STDP package
// Request types, configuration bundle, register indexes and the term table.
// ----------------------------------------------------------------------------
package stdp_pkg;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        pre_fired;
    logic        post_fired;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] weight;
    logic signed [31:0] step_change;
    logic signed [31:0] total_change;
    logic               updated;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         axon_delay;
    logic               rule_mode;
    logic               load_weight;
    logic signed [31:0] start_weight;
  } cfg_t;

  localparam logic [1:0] REG_AXON_DELAY   = 2'd0;
  localparam logic [1:0] REG_RULE_MODE    = 2'd1;
  localparam logic [1:0] REG_START_WEIGHT = 2'd2;

  localparam int LTP_MAX_K = 49;
  localparam int LTD_MAX_K = 74;

  localparam logic [63:0] EXP_BASE_Q32 = 64'd4168031829;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd3516421809;

  typedef logic [15:0] term_tab_t [0:127];

  // Build exp(-(k+0.15)/5) in Q0.16 by repeated Q0.32 multiplication.
  function automatic term_tab_t build_term_tab();
    term_tab_t   tab;
    logic [63:0] e;
    e = EXP_BASE_Q32;
    for (int i = 0; i < 128; i++) begin
      tab[i] = 16'((e + 64'd32768) >> 16);
      e = (e * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    return tab;
  endfunction

  localparam term_tab_t TERM_TAB = build_term_tab();

endpackage

### hw/rtl/stdp_synapse_weight_update_unit.sv
// An accepted request passes the read, evaluation and done states on the way to its result.
// A matching tick adds a pairing walk over the S pairs taken (0 to ring depth).
// The engine takes a new tick only once the last result is registered; a held result stalls it.
// Reset (rst_n low, synchronous): rings empty, indexes, weight, running total and
// configuration cleared; the ring valid bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
// STDP synapse weight update unit
// Pair-based STDP engine for one synapse with queue-style request ports.
// ----------------------------------------------------------------------------
module stdp_synapse_weight_update_unit #(
  parameter int SPIKE_RING_DEPTH = 16,
  parameter int TIME_BITS        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  stdp_pkg::in_item_t  in_item,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output stdp_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata
);
  import stdp_pkg::*;

  logic [7:0] axon_delay_r;
  logic       rule_mode_r;
  cfg_t       cfg;
  logic       q_valid, q_pop;
  in_item_t   q_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axon_delay_r <= '0;
      rule_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_AXON_DELAY: axon_delay_r <= cfg_wdata[7:0];
        REG_RULE_MODE:  rule_mode_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // A write to the start weight address loads the live weight; no start weight is stored.
  assign cfg.axon_delay   = axon_delay_r;
  assign cfg.rule_mode    = rule_mode_r;
  assign cfg.load_weight  = cfg_we && (cfg_addr == REG_START_WEIGHT);
  assign cfg.start_weight = cfg_wdata;

  stdp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  stdp_back #(
    .DEPTH     (SPIKE_RING_DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

### hw/rtl/stdp_front.sv
// ----------------------------------------------------------------------------
// STDP front end
// Two-entry request queue that decouples the tick source from the engine.
// ----------------------------------------------------------------------------
module stdp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  stdp_pkg::in_item_t in_item,
  output logic              in_full,
  output logic              q_valid,
  output stdp_pkg::in_item_t q_item,
  input  logic              q_pop
);
  import stdp_pkg::*;

  in_item_t   slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign in_full = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### hw/rtl/stdp_back.sv
// ----------------------------------------------------------------------------
// STDP back end
// Spike rings, pairing walk sequencer, weight update and result register.
// ----------------------------------------------------------------------------
module stdp_back #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stdp_pkg::cfg_t      cfg,
  input  logic                q_valid,
  input  stdp_pkg::in_item_t  q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output stdp_pkg::out_item_t out_item
);
  import stdp_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = $clog2(DEPTH + 1);
  localparam int TW = TIME_BITS;
  localparam int EW = TIME_BITS + 1;
  localparam int AW = SW + 17;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [TW-1:0]        t_r, t_in;
  logic [IW-1:0]        pre_wi_r, post_wi_r, pre_pi_r, post_pi_r;
  logic [DEPTH-1:0]     pre_vld_r, post_vld_r;
  logic [TW-1:0]        pre_mem [DEPTH];
  logic [TW-1:0]        post_mem [DEPTH];
  logic [TW-1:0]        pre_rd_r, post_rd_r;
  logic [IW-1:0]        pre_ra, post_ra;
  logic                 pot_r, first_r, upd_r;
  logic [EW-1:0]        tref_r, prev_r;
  logic [IW-1:0]        j_r;
  logic [SW-1:0]        steps_r;
  logic signed [AW-1:0] acc_r;
  logic signed [31:0]   weight_r, total_r;
  out_item_t            out_r;
  logic                 out_full_r;

  function automatic logic [IW-1:0] nxt_idx(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  assign t_in  = TW'(q_item.tick_time);
  assign q_pop = (state_r == S_IDLE) && q_valid;

  // Ring time stores with one registered read each.
  assign pre_ra  = (state_r == S_WALK) ? nxt_idx(j_r) : pre_pi_r;
  assign post_ra = (state_r == S_WALK) ? nxt_idx(j_r) : post_pi_r;

  always_ff @(posedge clk) begin
    if (q_pop && q_item.pre_fired) begin
      pre_mem[pre_wi_r] <= t_in;
    end
    if (q_pop && q_item.post_fired) begin
      post_mem[post_wi_r] <= t_in;
    end
    pre_rd_r  <= pre_mem[pre_ra];
    post_rd_r <= post_mem[post_ra];
  end

  // Pending-spike checks on the entries at the pending indexes.
  logic [EW-1:0] pre_sum, t_ext, post_ext;
  logic          post_now, pre_now;

  assign pre_sum  = {1'b0, pre_rd_r} + EW'(cfg.axon_delay);
  assign t_ext    = {1'b0, t_r};
  assign post_ext = {1'b0, post_rd_r};
  assign post_now = post_vld_r[post_pi_r] && (post_rd_r == t_r);
  assign pre_now  = pre_vld_r[pre_pi_r] && (pre_sum == t_ext);

  // One walk step: stop test and the pair term.
  logic                 w_vld, w_stop, w_inwin;
  logic [EW-1:0]        w_k;
  logic signed [AW-1:0] w_term;

  always_comb begin
    w_vld = pot_r ? pre_vld_r[j_r] : post_vld_r[j_r];
    if (pot_r) begin
      w_k    = tref_r - pre_sum;
      w_stop = !w_vld || (tref_r < pre_sum);
      w_inwin = (w_k <= EW'(LTP_MAX_K));
    end else begin
      w_k    = tref_r - post_ext;
      w_stop = !w_vld || (post_ext >= tref_r);
      w_inwin = (w_k <= EW'(LTD_MAX_K));
    end
    if (!first_r && (w_k >= prev_r)) w_stop = 1'b1;
    if (steps_r == SW'(DEPTH))       w_stop = 1'b1;
    w_term = '0;
    if (w_inwin) begin
      w_term = AW'(TERM_TAB[w_k[6:0]]);
      if (!pot_r) w_term = -w_term;
    end
  end

  // Final update arithmetic.
  logic signed [AW-1:0] dw;
  logic signed [32:0]   dw33, wsum, tsum;

  assign dw   = cfg.rule_mode ? -acc_r : acc_r;
  assign dw33 = 33'(dw);
  assign wsum = 33'(weight_r) + dw33;
  assign tsum = 33'(total_r) + dw33;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_RD;
      S_RD:    state_nxt = S_EVAL;
      S_EVAL:  state_nxt = (post_now || pre_now) ? S_WALK : S_DONE;
      S_WALK:  if (w_stop) state_nxt = S_DONE;
      S_DONE:  if (!out_full_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pre_wi_r   <= '0;
      post_wi_r  <= '0;
      pre_pi_r   <= '0;
      post_pi_r  <= '0;
      pre_vld_r  <= '0;
      post_vld_r <= '0;
      steps_r    <= '0;
      out_full_r <= 1'b0;
      weight_r   <= '0;
      total_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_pop && out_full_r) out_full_r <= 1'b0;
      if (cfg.load_weight) weight_r <= cfg.start_weight;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            t_r <= t_in;
            if (q_item.pre_fired) begin
              pre_vld_r[pre_wi_r] <= 1'b1;
              pre_wi_r <= nxt_idx(pre_wi_r);
            end
            if (q_item.post_fired) begin
              post_vld_r[post_wi_r] <= 1'b1;
              post_wi_r <= nxt_idx(post_wi_r);
            end
          end
        end
        S_RD: begin
        end
        S_EVAL: begin
          steps_r <= '0;
          first_r <= 1'b1;
          acc_r   <= '0;
          upd_r   <= post_now || pre_now;
          pot_r   <= post_now;
          if (post_now) begin
            tref_r <= t_ext;
            j_r    <= pre_pi_r;
          end else begin
            tref_r <= pre_sum;
            j_r    <= post_pi_r;
          end
        end
        S_WALK: begin
          if (w_stop) begin
            if (pot_r) pre_pi_r <= j_r;
            else       post_pi_r <= j_r;
          end else begin
            acc_r   <= acc_r + w_term;
            prev_r  <= w_k;
            first_r <= 1'b0;
            steps_r <= steps_r + 1'b1;
            j_r     <= nxt_idx(j_r);
          end
        end
        S_DONE: begin
          if (!out_full_r) begin
            weight_r            <= sat32(wsum);
            total_r             <= sat32(tsum);
            out_r.weight        <= sat32(wsum);
            out_r.total_change  <= sat32(tsum);
            out_r.step_change   <= dw33[31:0];
            out_r.updated       <= upd_r;
            out_full_r          <= 1'b1;
            steps_r             <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_empty = !out_full_r;
  assign out_item  = out_r;

`include "stdp_synapse_weight_update_unit_macros.svh"

  // The walk never takes more steps than the ring holds.
  `SWU_ASSERT(a_steps_bound, clk, rst_n, steps_r <= SW'(DEPTH), "walk overran the ring")
  // A new request always starts with a cleared step count.
  `SWU_ASSERT(a_idle_steps, clk, rst_n, (state_r != S_IDLE) || (steps_r == '0), "stale step count")
  // A request taken from the queue is always followed by the read state.
  `SWU_ASSERT_NEXT(a_pop_rd, clk, rst_n, q_pop, state_r == S_RD, "pop without read")
  // The evaluation step always leads into a walk or the result.
  `SWU_ASSERT_NEXT(a_eval_next, clk, rst_n, state_r == S_EVAL,
    (state_r == S_WALK) || (state_r == S_DONE), "bad state after evaluation")

endmodule

### test/stdp_synapse_weight_update_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// STDP synapse weight update unit testbench
// Drives ticks through the request queue, predicts each result with an
// in-bench pairing engine and checks every field under random back-pressure.
// ----------------------------------------------------------------------------
module stdp_synapse_weight_update_unit_tb;
  import stdp_pkg::*;

  localparam int RING = 16;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  in_item_t    in_item = '0;
  logic        in_full;
  logic        out_empty;
  logic        out_pop = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  stdp_synapse_weight_update_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_item(in_item), .in_full(in_full),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // Tick stream waiting to be sent and results still owed by the block.
  in_item_t  tick_queue[$];
  out_item_t weight_expect[$];
  int        send_idle_pct, pop_idle_pct;
  int        mismatches, ticks_sent, results_seen, updates_seen;

  // Shadow of the synapse state.
  bit          pre_ok[RING], post_ok[RING];
  longint      pre_t[RING], post_t[RING];
  int          pre_wr, post_wr, pre_pend, post_pend;
  int          delay_m, anti_m;
  logic signed [31:0] weight_m, total_m;
  longint      exp_term[0:127];

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Advance the pairing engine by one tick and queue the expected result.
  function automatic void predict_tick(in_item_t it);
    longint t, dw, prev, tp, k, tref;
    int pp, qp, steps, j;
    bit post_now, pre_now, upd;
    out_item_t r;
    t = it.tick_time; dw = 0; upd = 0; steps = 0;
    pp = pre_pend; qp = post_pend;
    if (it.pre_fired) begin
      pre_ok[pre_wr] = 1; pre_t[pre_wr] = t; pre_wr = (pre_wr + 1) % RING;
    end
    if (it.post_fired) begin
      post_ok[post_wr] = 1; post_t[post_wr] = t; post_wr = (post_wr + 1) % RING;
    end
    post_now = post_ok[qp] && post_t[qp] == t;
    pre_now = pre_ok[pp] && pre_t[pp] + delay_m == t;
    if (post_now) begin
      // Potentiation: walk pending presynaptic spikes toward the post spike.
      tref = post_t[qp]; prev = 100000; upd = 1;
      while (steps < RING) begin
        j = (pp + steps) % RING;
        if (!pre_ok[j]) break;
        tp = pre_t[j] + delay_m;
        if (tref < tp) break;
        k = tref - tp;
        if (k >= prev) break;
        if (k <= LTP_MAX_K) dw += exp_term[k];
        prev = k; steps++;
      end
      pre_pend = (pp + steps) % RING;
    end else if (pre_now) begin
      // Depression: walk pending postsynaptic spikes before the arrival.
      tref = pre_t[pp] + delay_m; prev = 1000000; upd = 1;
      while (steps < RING) begin
        j = (qp + steps) % RING;
        if (!post_ok[j]) break;
        tp = post_t[j];
        if (tp >= tref) break;
        k = tref - tp;
        if (k >= prev) break;
        if (k <= LTD_MAX_K) dw -= exp_term[k];
        prev = k; steps++;
      end
      post_pend = (qp + steps) % RING;
    end
    if (anti_m != 0) dw = -dw;
    weight_m = clamp32(longint'(weight_m) + dw);
    total_m = clamp32(longint'(total_m) + dw);
    r.weight = weight_m;
    r.step_change = clamp32(dw);
    r.total_change = total_m;
    r.updated = upd;
    weight_expect.push_back(r);
  endfunction

  // Sender: one request per accepted handshake, random gaps.
  always @(posedge clk) begin
    logic nxt;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      nxt = in_push;
      if (in_push && !in_full) begin
        predict_tick(in_item);
        ticks_sent++;
        nxt = 1'b0;
      end
      if (!nxt && tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= tick_queue.pop_front();
        nxt = 1'b1;
      end
      in_push <= nxt;
    end
  end

  // Receiver: random pops, each accepted result checked against the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (weight_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", out_item);
      end else begin
        e = weight_expect.pop_front();
        if (e.updated) updates_seen++;
        if (out_item.weight !== e.weight || out_item.step_change !== e.step_change ||
            out_item.total_change !== e.total_change || out_item.updated !== e.updated) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected w=%0d dw=%0d tot=%0d upd=%0b, ",
                      "got w=%0d dw=%0d tot=%0d upd=%0b"},
                     e.weight, e.step_change, e.total_change, e.updated,
                     out_item.weight, out_item.step_change, out_item.total_change,
                     out_item.updated);
        end
      end
    end
    out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_AXON_DELAY) delay_m = val[7:0];
    else if (idx == REG_RULE_MODE) anti_m = val[0];
    else if (idx == REG_START_WEIGHT) weight_m = val;
  endtask

  function automatic void add_tick(int t, bit pre, bit post);
    in_item_t it;
    it.tick_time = t[15:0]; it.pre_fired = pre; it.post_fired = post;
    tick_queue.push_back(it);
  endfunction

  // Mostly runs of consecutive ticks with random spikes, some random noise.
  function automatic void add_spike_train(int n, int max_gap);
    int t;
    t = $urandom_range(65535 - 4 * n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8)
        add_tick($urandom_range(65535), $urandom_range(1), $urandom_range(1));
      else begin
        t += (max_gap > 1 && $urandom_range(9) == 0) ? $urandom_range(max_gap) : 1;
        if (t > 65535) t = $urandom_range(1000);
        add_tick(t, $urandom_range(99) < 30, $urandom_range(99) < 30);
      end
    end
  endfunction

  task automatic drain();
    wait (tick_queue.size() == 0 && !in_push && weight_expect.size() == 0);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    longint e;
    e = 64'd4168031829;
    for (int i = 0; i < 128; i++) begin
      exp_term[i] = (e + 32768) >> 16;
      e = (e * 64'd3516421809 + 64'h8000_0000) >> 32;
    end
    for (int i = 0; i < RING; i++) begin
      pre_ok[i] = 0; post_ok[i] = 0; pre_t[i] = 0; post_t[i] = 0;
    end
    {pre_wr, post_wr, pre_pend, post_pend, delay_m, anti_m} = '0;
    weight_m = 0; total_m = 0;
    send_idle_pct = 13; pop_idle_pct = 85;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: time extremes, window edges for both rules, coincident spikes.
    add_tick(0, 1, 1); add_tick(65535, 1, 1);
    add_tick(100, 1, 0); add_tick(149, 0, 1);
    add_tick(200, 1, 0); add_tick(250, 0, 1);
    add_tick(300, 0, 1); add_tick(374, 1, 0);
    add_tick(400, 0, 1); add_tick(475, 1, 0);
    add_tick(500, 1, 0); add_tick(501, 1, 0); add_tick(502, 0, 1);
    add_tick(503, 1, 1); add_tick(504, 1, 1);
    for (int i = 0; i < 18; i++) add_tick(600 + i, 1, 0);
    for (int i = 0; i < 18; i++) add_tick(700 + i, 0, 1);
    add_tick(717, 1, 0);
    for (int i = 0; i < 5; i++) add_spike_train(100, 1);
    drain();

    // Delay and anti mode, weight near the top to reach saturation.
    send_idle_pct = 85; pop_idle_pct = 13;
    write_reg(REG_AXON_DELAY, 32'd3);
    write_reg(REG_RULE_MODE, 32'd1);
    write_reg(REG_START_WEIGHT, 32'h7ffe_0000);
    write_reg(REG_UNUSED, 32'hffff_ffff);
    for (int i = 0; i < 5; i++) add_spike_train(100, 4);
    drain();

    // Largest delay, most negative weight, then back to a small delay.
    send_idle_pct = 0; pop_idle_pct = 0;
    write_reg(REG_AXON_DELAY, 32'd255);
    write_reg(REG_RULE_MODE, 32'd0);
    write_reg(REG_START_WEIGHT, 32'h8000_0000);
    add_tick(1000, 1, 0); add_tick(1255, 0, 1); add_tick(1255, 1, 0);
    add_spike_train(150, 300);
    drain();
    write_reg(REG_AXON_DELAY, 32'd1);
    write_reg(REG_START_WEIGHT, 32'h0001_0000);
    add_spike_train(250, 2);
    drain();

    $display("Ran %0d ticks through %0d results, %0d of them with weight updates.",
             ticks_sent, results_seen, updates_seen);
    $display("Covered delays 0, 1, 3 and 255, both rule modes and weight extremes.");
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding", weight_expect.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/stdp_pkg.sv
hw/rtl/stdp_front.sv
hw/rtl/stdp_back.sv
hw/rtl/stdp_synapse_weight_update_unit.sv
test/stdp_synapse_weight_update_unit_tb.sv
